// ===== rtl/json_scalar_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// json_scalar_parser_top_macros : assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JSON_SCALAR_PARSER_TOP_MACROS_SVH
`define JSON_SCALAR_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property at every clock edge out of reset.
`define JSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition holds in the cycle after an event.
`define JSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define JSP_ASSERT(lbl, prop, msg)
`define JSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/jsp_pkg.sv =====
// ----------------------------------------------------------------------------
// jsp_pkg : shared types and tables of the JSON scalar parser
// Phase codes, status and type codes, parser state and literal tables.
// ----------------------------------------------------------------------------
package jsp_pkg;

  typedef enum logic [6:0] {
    PH_LEAD  = 7'b0000001,
    PH_LIT   = 7'b0000010,
    PH_NUM   = 7'b0000100,
    PH_STR   = 7'b0001000,
    PH_ESC   = 7'b0010000,
    PH_TRAIL = 7'b0100000,
    PH_ERR   = 7'b1000000
  } phase_t;

  typedef enum logic [7:0] {
    N_SIGN   = 8'b00000001,
    N_ZERO   = 8'b00000010,
    N_INT    = 8'b00000100,
    N_DOT    = 8'b00001000,
    N_FRAC   = 8'b00010000,
    N_EXP    = 8'b00100000,
    N_EXPSGN = 8'b01000000,
    N_EXPDIG = 8'b10000000
  } num_phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXPECT  = 3'd1,
    ST_INVALID = 3'd2,
    ST_NOTSING = 3'd3,
    ST_MISSQ   = 3'd4,
    ST_BADESC  = 3'd5,
    ST_BADCHAR = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    T_NULL   = 3'd0,
    T_FALSE  = 3'd1,
    T_TRUE   = 3'd2,
    T_NUMBER = 3'd3,
    T_STRING = 3'd4
  } vtype_t;

  typedef enum logic [1:0] {
    LK_TRUE  = 2'd0,
    LK_FALSE = 2'd1,
    LK_NULL  = 2'd2
  } lit_kind_t;

  typedef struct packed {
    phase_t     phase;
    num_phase_t nph;
    logic [1:0] lit_kind;
    logic [2:0] lit_pos;
    status_t    held_status;
    vtype_t     held_type;
  } jsp_state_t;

  typedef struct packed {
    logic       valid;
    logic       is_verdict;
    logic [7:0] str_byte;
    status_t    status;
    vtype_t     vtype;
    logic       last;
  } jsp_result_t;

  localparam jsp_state_t STATE_RESET = '{
    phase: PH_LEAD, nph: N_SIGN, lit_kind: 2'd0, lit_pos: 3'd0,
    held_status: ST_OK, held_type: T_NULL
  };

  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Expected character of a literal word at a given position
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      LK_TRUE: begin
        case (pos)
          3'd0: c = 8'h74;   // t
          3'd1: c = 8'h72;   // r
          3'd2: c = 8'h75;   // u
          3'd3: c = 8'h65;   // e
          default: c = 8'h00;
        endcase
      end
      LK_FALSE: begin
        case (pos)
          3'd0: c = 8'h66;   // f
          3'd1: c = 8'h61;   // a
          3'd2: c = 8'h6C;   // l
          3'd3: c = 8'h73;   // s
          3'd4: c = 8'h65;   // e
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: c = 8'h6E;   // n
          3'd1: c = 8'h75;   // u
          3'd2: c = 8'h6C;   // l
          3'd3: c = 8'h6C;   // l
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_size(input logic [1:0] k);
    return (k == LK_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic vtype_t lit_type(input logic [1:0] k);
    vtype_t t;
    case (k)
      LK_TRUE:  t = T_TRUE;
      LK_FALSE: t = T_FALSE;
      default:  t = T_NULL;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/json_scalar_parser_top.sv =====
// ----------------------------------------------------------------------------
// json_scalar_parser_top : streaming checker for one JSON scalar
// Usage:
//   Slave side carries one text character per transfer in in_tdata; in_tlast
//   high marks end of text (the character is then ignored). Master side
//   carries decoded string characters (out_tuser low) and, at end of text,
//   one verdict (out_tuser and out_tlast high) with status and value type.
//   A consumer drops the string characters of a text whose verdict reports
//   an error.
//   A result passes from the input register through the combinational
//   parser step straight into the result register.
//   Throughput: one character per cycle while the receiver does not stall,
//   set by the parser step between the input register and the result register.
//   Reset clears the valid flags of both registers and returns the parser
//   to the leading-whitespace phase; no clearing pass is needed.
//   When the receiver stalls, the result register holds, the parser step
//   waits with its character in the input register, and in_tready drops
//   once that register is full. Items that give no result still wait for
//   a free result slot.
// ----------------------------------------------------------------------------
module json_scalar_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] text_byte
  input  logic        in_tlast,    // is_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] string_byte, [10:8] status,
                                   // [13:11] value_type, [15:14] zero
  output logic        out_tuser,   // is_verdict
  output logic        out_tlast    // last
);
  import jsp_pkg::*;

`include "json_scalar_parser_top_macros.svh"

  // Input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_end_r;

  // Parser state
  jsp_state_t  state_r;
  jsp_state_t  state_nxt;
  jsp_result_t res;

  logic        slot_free;
  logic        fire;

  // Advance the parser when a character waits and the result slot is free
  assign fire      = in_valid_r && slot_free;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  jsp_step u_step (
    .state     (state_r),
    .text_byte (in_byte_r),
    .is_end    (in_end_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  jsp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && res.valid),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A verdict starts a new text in the leading-whitespace phase
  `JSP_ASSERT_NEXT(a_rewind, fire && in_end_r, state_r.phase == PH_LEAD, "not rewound")
  // An error phase always carries an error status
  `JSP_ASSERT(a_err_st, state_r.phase == PH_ERR |-> state_r.held_status != ST_OK, "ok in error")
  // A full input register facing a stalled result must hold the slave side
  `JSP_ASSERT(a_stall, in_valid_r && out_tvalid && !out_tready |-> !in_tready, "taken in stall")

endmodule

// ===== rtl/jsp_step.sv =====
// ----------------------------------------------------------------------------
// jsp_step : one parser step
// Next parser state and the result item caused by one text byte or end mark.
// ----------------------------------------------------------------------------
module jsp_step (
  input  jsp_pkg::jsp_state_t  state,
  input  logic [7:0]           text_byte,
  input  logic                 is_end,
  output jsp_pkg::jsp_state_t  state_nxt,
  output jsp_pkg::jsp_result_t res
);
  import jsp_pkg::*;

  logic       dig;
  logic       ws;
  logic [1:0] k;
  logic [2:0] pos_inc;
  status_t    v_st;
  vtype_t     v_ty;

  assign dig     = is_digit(text_byte);
  assign ws      = is_ws(text_byte);
  assign k       = (state.lit_kind == 2'd3) ? LK_NULL : state.lit_kind;
  assign pos_inc = state.lit_pos + 3'd1;

  // Verdict at end of text
  always_comb begin
    v_st = state.held_status;
    v_ty = state.held_type;
    case (state.phase)
      PH_LEAD: v_st = ST_EXPECT;
      PH_LIT:  v_st = ST_INVALID;
      PH_NUM: begin
        if (state.nph == N_ZERO || state.nph == N_INT ||
            state.nph == N_FRAC || state.nph == N_EXPDIG) begin
          v_st = ST_OK;
          v_ty = T_NUMBER;
        end else begin
          v_st = ST_INVALID;
        end
      end
      PH_STR:   v_st = ST_MISSQ;
      PH_ESC:   v_st = ST_BADESC;
      PH_TRAIL: v_st = ST_OK;
      default:  v_st = state.held_status;
    endcase
    if (v_st != ST_OK) v_ty = T_NULL;
  end

  always_comb begin
    state_nxt      = state;
    res.valid      = 1'b0;
    res.is_verdict = 1'b0;
    res.str_byte   = text_byte;
    res.status     = ST_OK;
    res.vtype      = T_STRING;
    res.last       = 1'b0;

    if (is_end) begin
      state_nxt      = STATE_RESET;
      res.valid      = 1'b1;
      res.is_verdict = 1'b1;
      res.str_byte   = 8'h00;
      res.status     = v_st;
      res.vtype      = v_ty;
      res.last       = 1'b1;
    end else begin
      case (state.phase)
        PH_LEAD: begin
          if (!ws) begin
            if (text_byte == 8'h74 || text_byte == 8'h66 || text_byte == 8'h6E) begin
              state_nxt.lit_kind = (text_byte == 8'h74) ? LK_TRUE :
                                   (text_byte == 8'h66) ? LK_FALSE : LK_NULL;
              state_nxt.lit_pos  = 3'd1;
              state_nxt.phase    = PH_LIT;
            end else if (text_byte == 8'h22) begin
              state_nxt.phase = PH_STR;
            end else if (text_byte == 8'h2D) begin
              state_nxt.nph   = N_SIGN;
              state_nxt.phase = PH_NUM;
            end else if (text_byte == 8'h30) begin
              state_nxt.nph   = N_ZERO;
              state_nxt.phase = PH_NUM;
            end else if (dig) begin
              state_nxt.nph   = N_INT;
              state_nxt.phase = PH_NUM;
            end else begin
              state_nxt.phase       = PH_ERR;
              state_nxt.held_status = ST_INVALID;
              state_nxt.held_type   = T_NULL;
            end
          end
        end

        PH_LIT: begin
          if (state.lit_pos < lit_size(k) && text_byte == lit_char(k, state.lit_pos)) begin
            state_nxt.lit_pos = pos_inc;
            if (pos_inc == lit_size(k)) begin
              state_nxt.held_type = lit_type(k);
              state_nxt.phase     = PH_TRAIL;
            end
          end else begin
            state_nxt.phase       = PH_ERR;
            state_nxt.held_status = ST_INVALID;
            state_nxt.held_type   = T_NULL;
          end
        end

        PH_NUM: begin
          case (state.nph)
            N_SIGN: begin
              if (text_byte == 8'h30) state_nxt.nph = N_ZERO;
              else if (dig)           state_nxt.nph = N_INT;
              else begin
                state_nxt.phase       = PH_ERR;
                state_nxt.held_status = ST_INVALID;
                state_nxt.held_type   = T_NULL;
              end
            end
            N_ZERO, N_INT, N_FRAC: begin
              if (dig && state.nph != N_ZERO) begin
                state_nxt.nph = state.nph;
              end else if (text_byte == 8'h2E && state.nph != N_FRAC) begin
                state_nxt.nph = N_DOT;
              end else if (text_byte == 8'h65 || text_byte == 8'h45) begin
                state_nxt.nph = N_EXP;
              end else if (ws) begin
                state_nxt.held_type = T_NUMBER;
                state_nxt.phase     = PH_TRAIL;
              end else begin
                state_nxt.phase       = PH_ERR;
                state_nxt.held_status = ST_NOTSING;
                state_nxt.held_type   = T_NULL;
              end
            end
            N_DOT, N_EXPSGN: begin
              if (dig && state.nph == N_DOT) state_nxt.nph = N_FRAC;
              else if (dig)                  state_nxt.nph = N_EXPDIG;
              else begin
                state_nxt.phase       = PH_ERR;
                state_nxt.held_status = ST_INVALID;
                state_nxt.held_type   = T_NULL;
              end
            end
            N_EXP: begin
              if (text_byte == 8'h2B || text_byte == 8'h2D) state_nxt.nph = N_EXPSGN;
              else if (dig)                                 state_nxt.nph = N_EXPDIG;
              else begin
                state_nxt.phase       = PH_ERR;
                state_nxt.held_status = ST_INVALID;
                state_nxt.held_type   = T_NULL;
              end
            end
            default: begin
              // exponent digits: a non-digit ends the number
              if (!dig) begin
                if (ws) begin
                  state_nxt.held_type = T_NUMBER;
                  state_nxt.phase     = PH_TRAIL;
                end else begin
                  state_nxt.phase       = PH_ERR;
                  state_nxt.held_status = ST_NOTSING;
                  state_nxt.held_type   = T_NULL;
                end
              end
            end
          endcase
        end

        PH_STR: begin
          if (text_byte == 8'h22) begin
            state_nxt.held_type = T_STRING;
            state_nxt.phase     = PH_TRAIL;
          end else if (text_byte == 8'h5C) begin
            state_nxt.phase = PH_ESC;
          end else if (text_byte < CTRL_LIMIT) begin
            state_nxt.phase       = PH_ERR;
            state_nxt.held_status = ST_BADCHAR;
            state_nxt.held_type   = T_NULL;
          end else begin
            res.valid = 1'b1;
          end
        end

        PH_ESC: begin
          res.valid       = 1'b1;
          state_nxt.phase = PH_STR;
          case (text_byte)
            8'h22, 8'h5C, 8'h2F: res.str_byte = text_byte;
            8'h62:               res.str_byte = 8'h08;   // b
            8'h66:               res.str_byte = 8'h0C;   // f
            8'h6E:               res.str_byte = 8'h0A;   // n
            8'h72:               res.str_byte = 8'h0D;   // r
            8'h74:               res.str_byte = 8'h09;   // t
            default: begin
              res.valid             = 1'b0;
              state_nxt.phase       = PH_ERR;
              state_nxt.held_status = ST_BADESC;
              state_nxt.held_type   = T_NULL;
            end
          endcase
        end

        PH_TRAIL: begin
          if (!ws) begin
            state_nxt.phase       = PH_ERR;
            state_nxt.held_status = ST_NOTSING;
            state_nxt.held_type   = T_NULL;
          end
        end

        default: state_nxt = state;
      endcase
    end
  end

endmodule

// ===== rtl/jsp_out_stage.sv =====
// ----------------------------------------------------------------------------
// jsp_out_stage : result register
// Hold one result item towards the master-side stream until it transfers.
// ----------------------------------------------------------------------------
module jsp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  jsp_pkg::jsp_result_t res,
  output logic                 slot_free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,   // [7:0] string_byte, [10:8] status,
                                            // [13:11] value_type, [15:14] zero
  output logic                 out_tuser,   // is_verdict
  output logic                 out_tlast    // last
);
  import jsp_pkg::*;

  logic       valid_r;
  logic [7:0] str_byte_r;
  status_t    status_r;
  vtype_t     vtype_r;
  logic       verdict_r;
  logic       last_r;

  assign slot_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      str_byte_r <= res.str_byte;
      status_r   <= res.status;
      vtype_r    <= res.vtype;
      verdict_r  <= res.is_verdict;
      last_r     <= res.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, vtype_r, status_r, str_byte_r};
  assign out_tuser  = verdict_r;
  assign out_tlast  = last_r;

endmodule

// ===== bench/json_scalar_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// json_scalar_parser_top_tb : self-checking bench for the JSON scalar parser
// Feeds texts one character per transfer, closes each with an end marker and
// checks every decoded string character and verdict against an in-bench
// parser or a typed table row. A short directed table comes first, then random
// texts, mostly well-formed, under four idling regimes on the two stream sides.
// ----------------------------------------------------------------------------
module json_scalar_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsp_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int PHASE_ITEMS  = 300;   // random characters per idling regime
  localparam int DRAIN_CYCLES = 10;    // margin after the last drain
  localparam int PRINT_CAP    = 40;

  // Parser position within one text
  typedef enum int {
    LEADING, IN_LITERAL, IN_NUMBER, IN_STRING, IN_ESCAPE, TRAILING, FAILED
  } parse_phase_t;

  // Position within number syntax
  typedef enum int {
    NUM_SIGN, NUM_ZERO, NUM_INT, NUM_DOT, NUM_FRAC, NUM_EXP, NUM_EXPSGN, NUM_EXPDIG
  } num_state_t;

  // One item on the result stream
  typedef struct packed {
    logic       is_verdict;
    logic [7:0] chr;
    status_t    st;
    vtype_t     ty;
    logic       last;
  } reply_t;

  // One row of the directed table; a typed row carries its verdict inline
  typedef struct {
    logic [7:0] chr;
    logic       is_end;
    logic       typed;
    status_t    st;
    vtype_t     ty;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] text_byte
  logic        in_tlast = 1'b0;    // is_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] string_byte, [10:8] status,
                                   // [13:11] value_type, [15:14] zero
  logic        out_tuser;          // is_verdict
  logic        out_tlast;          // last

  json_scalar_parser_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Literal words, their value types, escape letters and blank characters
  string      lit_words [3] = '{"true", "false", "null"};
  vtype_t     lit_types [3] = '{T_TRUE, T_FALSE, T_NULL};
  string      esc_letters   = "\"\\/bfnrt";
  logic [7:0] blank_set [4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};

  // In-bench parser state
  parse_phase_t ph;
  num_state_t   num_ph;
  int           lk;
  int           lit_pos;
  status_t      held_st;
  vtype_t       held_ty;

  reply_t     parse_out_q [$];   // decoded characters and verdicts still due
  text_row_t  dir_rows [$];
  logic [7:0] text_q [$];

  int gap_pct   = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  int quiet_cycles = 0;
  int mismatches = 0;
  int useful_items = 0;
  int texts_sent = 0;
  int chars_seen = 0;
  int verdicts_seen = 0;
  int status_seen [7] = '{default: 0};

  // --------------------------------------------------------------------------
  // Parser prediction
  // --------------------------------------------------------------------------
  function automatic bit is_blank(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0A, 8'h0D};
  endfunction

  function automatic void parser_clear();
    ph      = LEADING;
    num_ph  = NUM_SIGN;
    lk      = 0;
    lit_pos = 0;
    held_st = ST_OK;
    held_ty = T_NULL;
  endfunction

  function automatic void fail_with(input status_t st);
    ph      = FAILED;
    held_st = st;
    held_ty = T_NULL;
  endfunction

  // A number has ended and b is the first character after it
  function automatic void close_number(input logic [7:0] b);
    held_ty = T_NUMBER;
    if (is_blank(b)) ph = TRAILING;
    else fail_with(ST_NOTSING);
  endfunction

  function automatic void push_char(input logic [7:0] b);
    parse_out_q.push_back('{1'b0, b, ST_OK, T_STRING, 1'b0});
  endfunction

  // Advance the parser by one accepted transfer and queue what it yields
  function automatic void parse_char(input logic [7:0] b, input logic is_end);
    status_t st;
    vtype_t  ty;
    bit      dig;
    dig = (b >= "0") && (b <= "9");
    if (is_end) begin
      st = held_st;
      ty = held_ty;
      case (ph)
        LEADING:    st = ST_EXPECT;
        IN_LITERAL: st = ST_INVALID;
        IN_NUMBER: begin
          if (num_ph == NUM_ZERO || num_ph == NUM_INT || num_ph == NUM_FRAC ||
              num_ph == NUM_EXPDIG) begin
            st = ST_OK;
            ty = T_NUMBER;
          end else begin
            st = ST_INVALID;
          end
        end
        IN_STRING:  st = ST_MISSQ;
        IN_ESCAPE:  st = ST_BADESC;
        TRAILING:   st = ST_OK;
        default:    ;
      endcase
      if (st != ST_OK) ty = T_NULL;
      parse_out_q.push_back('{1'b1, 8'h00, st, ty, 1'b1});
      parser_clear();
      return;
    end
    case (ph)
      LEADING: begin
        if (b == "t" || b == "f" || b == "n") begin
          lk      = (b == "t") ? 0 : (b == "f") ? 1 : 2;
          lit_pos = 1;
          ph      = IN_LITERAL;
        end else if (b == "\"") begin
          ph = IN_STRING;
        end else if (b == "-") begin
          num_ph = NUM_SIGN;
          ph     = IN_NUMBER;
        end else if (b == "0") begin
          num_ph = NUM_ZERO;
          ph     = IN_NUMBER;
        end else if (dig) begin
          num_ph = NUM_INT;
          ph     = IN_NUMBER;
        end else if (!is_blank(b)) begin
          // anything else is read as a malformed number
          fail_with(ST_INVALID);
        end
      end
      IN_LITERAL: begin
        if (b == lit_words[lk][lit_pos]) begin
          lit_pos++;
          if (lit_pos == lit_words[lk].len()) begin
            held_ty = lit_types[lk];
            ph      = TRAILING;
          end
        end else begin
          fail_with(ST_INVALID);
        end
      end
      IN_NUMBER: begin
        case (num_ph)
          NUM_SIGN: begin
            if (b == "0") num_ph = NUM_ZERO;
            else if (dig) num_ph = NUM_INT;
            else fail_with(ST_INVALID);
          end
          NUM_ZERO, NUM_INT, NUM_FRAC: begin
            // digits extend the integer or fraction, but never a leading zero
            if (!(dig && num_ph != NUM_ZERO)) begin
              if (b == "." && num_ph != NUM_FRAC) num_ph = NUM_DOT;
              else if (b == "e" || b == "E") num_ph = NUM_EXP;
              else close_number(b);
            end
          end
          NUM_DOT: begin
            if (dig) num_ph = NUM_FRAC;
            else fail_with(ST_INVALID);
          end
          NUM_EXP: begin
            if (b == "+" || b == "-") num_ph = NUM_EXPSGN;
            else if (dig) num_ph = NUM_EXPDIG;
            else fail_with(ST_INVALID);
          end
          NUM_EXPSGN: begin
            if (dig) num_ph = NUM_EXPDIG;
            else fail_with(ST_INVALID);
          end
          default: begin
            if (!dig) close_number(b);
          end
        endcase
      end
      IN_STRING: begin
        if (b == "\"") begin
          held_ty = T_STRING;
          ph      = TRAILING;
        end else if (b == "\\") begin
          ph = IN_ESCAPE;
        end else if (b < 8'h20) begin
          fail_with(ST_BADCHAR);
        end else begin
          push_char(b);
        end
      end
      IN_ESCAPE: begin
        ph = IN_STRING;
        case (b)
          "\"", "\\", "/": push_char(b);
          "b":     push_char(8'h08);
          "f":     push_char(8'h0C);
          "n":     push_char(8'h0A);
          "r":     push_char(8'h0D);
          "t":     push_char(8'h09);
          default: fail_with(ST_BADESC);   // backslash-u lands here too
        endcase
      end
      TRAILING: begin
        if (!is_blank(b)) fail_with(ST_NOTSING);
      end
      default: ;   // after an error, drop everything up to the end marker
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch on %s: want %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic check_reply();
    reply_t want;
    if (parse_out_q.size() == 0) begin
      report_mismatch("unexpected transfer", 16'h0000, out_tdata);
      return;
    end
    want = parse_out_q.pop_front();
    if (out_tuser !== want.is_verdict)
      report_mismatch("is_verdict", 16'(want.is_verdict), 16'(out_tuser));
    if (out_tdata[7:0] !== want.chr)
      report_mismatch("string_byte", 16'(want.chr), 16'(out_tdata[7:0]));
    if (out_tdata[10:8] !== want.st)
      report_mismatch("status", 16'(want.st), 16'(out_tdata[10:8]));
    if (out_tdata[13:11] !== want.ty)
      report_mismatch("value_type", 16'(want.ty), 16'(out_tdata[13:11]));
    if (out_tlast !== want.last)
      report_mismatch("last", 16'(want.last), 16'(out_tlast));
    if (out_tdata[15:14] !== 2'b00)
      report_mismatch("tdata padding", 16'h0000, 16'(out_tdata[15:14]));
    if (want.is_verdict) begin
      verdicts_seen++;
      status_seen[want.st]++;
    end else begin
      chars_seen++;
    end
  endtask

  // Sample the result side and count quiet cycles at every rising edge
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_tvalid && out_tready) check_reply();
  end

  // Stall the receiver at random according to the current regime
  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Abort a run that has stopped moving
  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("** json_scalar_parser_top: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Hold off at random, then present one transfer and wait for it to go
  task automatic send_item(input logic [7:0] b, input logic is_end);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_end;
    do @(posedge clk); while (!in_tready);
    if (ph != FAILED || is_end) useful_items++;
    if (is_end) texts_sent++;
    parse_char(b, is_end);
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (parse_out_q.size() != 0);
  endtask

  task automatic add_byte(input logic [7:0] b);
    dir_rows.push_back('{b, 1'b0, 1'b0, ST_OK, T_NULL});
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_end(input logic typed, input status_t st, input vtype_t ty);
    dir_rows.push_back('{8'($urandom_range(255)), 1'b1, typed, st, ty});
  endtask

  function automatic logic [7:0] pick_blank();
    return blank_set[$urandom_range(3)];
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'($urandom_range(8'h39, 8'h30));
  endfunction

  // Build one random text: mostly well-formed values with random content,
  // some noise and empty texts, and a share broken by one changed or inserted character or a cut tail
  task automatic build_text();
    int         kind;
    int         n;
    logic [7:0] c;
    text_q.delete();
    repeat ($urandom_range(2)) text_q.push_back(pick_blank());
    kind = $urandom_range(99);
    if (kind < 20) begin
      n = $urandom_range(2);
      for (int i = 0; i < lit_words[n].len(); i++) text_q.push_back(lit_words[n][i]);
    end else if (kind < 50) begin
      if ($urandom_range(99) < 30) text_q.push_back("-");
      if ($urandom_range(99) < 25) begin
        text_q.push_back("0");
      end else begin
        text_q.push_back(8'($urandom_range(8'h39, 8'h31)));
        repeat ($urandom_range(3)) text_q.push_back(pick_digit());
      end
      if ($urandom_range(99) < 40) begin
        text_q.push_back(".");
        repeat ($urandom_range(3, 1)) text_q.push_back(pick_digit());
      end
      if ($urandom_range(99) < 30) begin
        text_q.push_back($urandom_range(1) ? "e" : "E");
        if ($urandom_range(1)) text_q.push_back($urandom_range(1) ? "+" : "-");
        repeat ($urandom_range(2, 1)) text_q.push_back(pick_digit());
      end
    end else if (kind < 80) begin
      text_q.push_back("\"");
      repeat ($urandom_range(6)) begin
        if ($urandom_range(99) < 20) begin
          text_q.push_back("\\");
          if ($urandom_range(99) < 85) text_q.push_back(esc_letters[$urandom_range(7)]);
          else text_q.push_back(8'($urandom_range(255)));
        end else begin
          c = 8'($urandom_range(255, 32));
          if (c == "\"" || c == "\\") c = "a";
          text_q.push_back(c);
        end
      end
      text_q.push_back("\"");
    end else if (kind < 90) begin
      repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255)));
    end
    repeat ($urandom_range(2)) text_q.push_back(pick_blank());
    if (text_q.size() != 0 && $urandom_range(99) < 15) begin
      case ($urandom_range(2))
        0: text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
        1: repeat ($urandom_range(text_q.size())) void'(text_q.pop_back());
        default: text_q.insert($urandom_range(text_q.size()), 8'($urandom_range(255)));
      endcase
    end
  endtask

  int gap_table   [4] = '{0, 72, 0, 17};
  int stall_table [4] = '{0, 0, 72, 17};

  initial begin
    parser_clear();

    // Directed table: extremes of the character, end before any value,
    // unknown and zero first characters, escapes, control characters,
    // numbers cut short and numbers followed by more text
    add_end(1'b1, ST_EXPECT, T_NULL);
    add_byte(8'h00);                  add_end(1'b1, ST_INVALID, T_NULL);
    add_str("\""); add_byte(8'hFF);
    add_str("\\");                    add_end(1'b1, ST_BADESC, T_NULL);
    add_str("\"\\u\"");               add_end(1'b1, ST_BADESC, T_NULL);
    add_str("\"\\t");                 add_end(1'b1, ST_MISSQ, T_NULL);
    add_str("\""); add_byte(8'h1F);   add_end(1'b1, ST_BADCHAR, T_NULL);
    add_str("01");                    add_end(1'b1, ST_NOTSING, T_NULL);
    add_str("-");                     add_end(1'b1, ST_INVALID, T_NULL);
    add_str("\t1\r");                 add_end(1'b0, ST_OK, T_NULL);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].chr, dir_rows[i].is_end);
      // overwrite the predicted verdict with the one written in the table
      if (dir_rows[i].typed)
        parse_out_q[parse_out_q.size() - 1] =
          '{1'b1, 8'h00, dir_rows[i].st, dir_rows[i].ty, 1'b1};
    end
    drain_results();

    // Random texts, one idling regime after another; pause between regimes
    // until the result side has caught up
    for (int p = 0; p < 4; p++) begin
      gap_pct      = gap_table[p];
      stall_pct    = stall_table[p];
      useful_items = 0;
      while (useful_items < PHASE_ITEMS) begin
        build_text();
        foreach (text_q[i]) send_item(text_q[i], 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d texts: %0d decoded characters and %0d verdicts checked",
             texts_sent, chars_seen, verdicts_seen);
    $display("Verdict statuses 0 to 6: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (mismatches == 0) begin
      $display("** json_scalar_parser_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** json_scalar_parser_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jsp_pkg.sv
rtl/jsp_step.sv
rtl/jsp_out_stage.sv
rtl/json_scalar_parser_top.sv
bench/json_scalar_parser_top_tb.sv
